>>> rtl/mppt_pkg.sv
package mppt_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int POS_W           = 12;
    localparam int BTN_W           = 5;
    localparam int BOUND_W         = 13;
    localparam int SCALE_W         = 4;
    localparam int MOVE_W          = 14;
    localparam int LIFT_W          = 8;
    localparam int SUM_W           = 18;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    localparam logic [2:0] REG_FOUR_BYTE = 3'd0;
    localparam logic [2:0] REG_WHEEL_EN  = 3'd1;
    localparam logic [2:0] REG_EXTRA_EN  = 3'd2;
    localparam logic [2:0] REG_BOUND_X   = 3'd3;
    localparam logic [2:0] REG_BOUND_Y   = 3'd4;
    localparam logic [2:0] REG_SCALE     = 3'd5;

    localparam logic [BOUND_W-1:0] BOUND_X_RST = 13'd1024;
    localparam logic [BOUND_W-1:0] BOUND_Y_RST = 13'd768;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 4'd2;
    localparam logic [SCALE_W-1:0] SCALE_MIN   = 4'd1;
    localparam logic [SCALE_W-1:0] SCALE_MAX   = 4'd8;
    localparam int                 PTR_X_RST   = 400;
    localparam int                 PTR_Y_RST   = 300;
    localparam logic [LIFT_W-1:0]  WHEEL_STEP  = 8'd12;

    typedef struct packed {
        logic               four_byte;
        logic               wheel_en;
        logic               extra_en;
        logic [BOUND_W-1:0] bound_x;
        logic [BOUND_W-1:0] bound_y;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic set_x;
        logic set_y;
    } recenter_t;

    typedef struct packed {
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
        logic signed [LIFT_W-1:0] lift;
        logic        [BTN_W-1:0]  buttons;
    } pkt_t;

    function automatic logic [SUM_W-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v,
        input logic [BOUND_W-1:0]      b
    );
        logic signed [SUM_W-1:0] lim;
        lim = $signed(SUM_W'(b));
        if (v[SUM_W-1])
        begin
            return '0;
        end
        else if (v >= lim)
        begin
            return SUM_W'(b) - SUM_W'(1);
        end
        return v;
    endfunction

endpackage

>>> rtl/mppt_regs.sv
module mppt_regs
    import mppt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg,
    output recenter_t         recenter
);

    localparam int LIMIT = 1 << COORD_WIDTH;

    logic               four_reg;
    logic               wheel_reg;
    logic               extra_reg;
    logic [BOUND_W-1:0] bound_x_reg;
    logic [BOUND_W-1:0] bound_y_reg;
    logic [SCALE_W-1:0] scale_reg;
    recenter_t          recenter_reg;
    recenter_t          recenter_next;

    logic               wr;
    logic [2:0]         idx;
    logic [BOUND_W-1:0] wr_bound;
    logic [BOUND_W-1:0] bound_x_next;
    logic [BOUND_W-1:0] bound_y_next;
    logic [SCALE_W-1:0] scale_next;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign wr_bound = pwdata[BOUND_W-1:0];

    // zero keeps the old bound, oversize saturates to the coordinate range
    always_comb
    begin
        bound_x_next = bound_x_reg;
        bound_y_next = bound_y_reg;
        if (wr_bound != '0)
        begin
            if (32'(wr_bound) > LIMIT)
            begin
                bound_x_next = BOUND_W'(LIMIT);
                bound_y_next = BOUND_W'(LIMIT);
            end
            else
            begin
                bound_x_next = wr_bound;
                bound_y_next = wr_bound;
            end
        end
    end

    always_comb
    begin
        scale_next = pwdata[SCALE_W-1:0];
        if (scale_next < SCALE_MIN)
        begin
            scale_next = SCALE_MIN;
        end
        else if (scale_next > SCALE_MAX)
        begin
            scale_next = SCALE_MAX;
        end
    end

    always_comb
    begin
        recenter_next.set_x = wr && (idx == REG_BOUND_X);
        recenter_next.set_y = wr && (idx == REG_BOUND_Y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_reg     <= 1'b0;
            wheel_reg    <= 1'b0;
            extra_reg    <= 1'b0;
            bound_x_reg  <= BOUND_X_RST;
            bound_y_reg  <= BOUND_Y_RST;
            scale_reg    <= SCALE_RST;
            recenter_reg <= '0;
        end
        else
        begin
            recenter_reg <= recenter_next;
            if (wr)
            begin
                case (idx)
                    REG_FOUR_BYTE: four_reg    <= pwdata[0];
                    REG_WHEEL_EN:  wheel_reg   <= pwdata[0];
                    REG_EXTRA_EN:  extra_reg   <= pwdata[0];
                    REG_BOUND_X:   bound_x_reg <= bound_x_next;
                    REG_BOUND_Y:   bound_y_reg <= bound_y_next;
                    REG_SCALE:     scale_reg   <= scale_next;
                    default:       ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_FOUR_BYTE: prdata = DATA_W'(four_reg);
            REG_WHEEL_EN:  prdata = DATA_W'(wheel_reg);
            REG_EXTRA_EN:  prdata = DATA_W'(extra_reg);
            REG_BOUND_X:   prdata = DATA_W'(bound_x_reg);
            REG_BOUND_Y:   prdata = DATA_W'(bound_y_reg);
            REG_SCALE:     prdata = DATA_W'(scale_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.four_byte = four_reg;
    assign cfg.wheel_en  = wheel_reg;
    assign cfg.extra_en  = extra_reg;
    assign cfg.bound_x   = bound_x_reg;
    assign cfg.bound_y   = bound_y_reg;
    assign cfg.scale     = scale_reg;
    assign recenter      = recenter_reg;

endmodule

>>> rtl/mppt_framer.sv
module mppt_framer
    import mppt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    input  logic       drain,
    output logic       pkt_valid,
    output pkt_t       pkt
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] held_reg [3];
    logic       pkt_valid_reg;
    logic       pkt_valid_next;
    pkt_t       pkt_reg;
    pkt_t       pkt_next;

    logic                     drop;
    logic                     complete;
    logic                     size4;
    logic [7:0]               flags;
    logic [7:0]               b1;
    logic [7:0]               b2;
    logic signed [MOVE_W-1:0] dx;
    logic signed [MOVE_W-1:0] dy;
    logic signed [MOVE_W-1:0] scale_s;
    logic signed [LIFT_W-1:0] wheel;

    assign size4    = cfg.four_byte;
    assign drop     = (pos_reg == 2'd0) && !data_byte[3];
    assign complete = !drop && (size4 ? (pos_reg == 2'd3) : (pos_reg >= 2'd2));

    always_comb
    begin
        pos_next = pos_reg;
        if (accept && !drop)
        begin
            pos_next = complete ? 2'd0 : pos_reg + 2'd1;
        end
    end

    // the completing byte is still on the input, not yet in the hold line
    assign flags = held_reg[0];
    assign b1    = held_reg[1];
    assign b2    = (pos_reg == 2'd2) ? data_byte : held_reg[2];

    always_comb
    begin
        dx      = flags[6] ? '0 : MOVE_W'($signed({flags[4], b1}));
        dy      = flags[7] ? '0 : MOVE_W'($signed({flags[5], b2}));
        scale_s = $signed(MOVE_W'(cfg.scale));
        wheel   = LIFT_W'($signed(data_byte[3:0]));

        pkt_next.move_x  = dx * scale_s;
        pkt_next.move_y  = dy * scale_s;
        pkt_next.lift    = '0;
        pkt_next.buttons = BTN_W'(flags[2:0]);
        if (size4)
        begin
            if (cfg.wheel_en)
            begin
                pkt_next.lift = '0 - wheel * $signed(WHEEL_STEP);
            end
            if (cfg.extra_en)
            begin
                pkt_next.buttons[3] = data_byte[4];
                pkt_next.buttons[4] = data_byte[5];
            end
        end
    end

    always_comb
    begin
        pkt_valid_next = pkt_valid_reg;
        if (accept && complete)
        begin
            pkt_valid_next = 1'b1;
        end
        else if (drain)
        begin
            pkt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !drop)
        begin
            case (pos_reg)
                2'd0:    held_reg[0] <= data_byte;
                2'd1:    held_reg[1] <= data_byte;
                2'd2:    held_reg[2] <= data_byte;
                default: ;
            endcase
        end
        if (accept && complete)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

>>> rtl/mppt_mover.sv
module mppt_mover
    import mppt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             drain,
    input  pkt_t             pkt,
    input  cfg_t             cfg,
    input  recenter_t        recenter,
    input  logic             result_stall,
    output logic             result_valid,
    output logic [POS_W-1:0] pos_x,
    output logic [POS_W-1:0] pos_y,
    output logic [BTN_W-1:0] button_bits
);

    logic [COORD_WIDTH-1:0] ptr_x_reg;
    logic [COORD_WIDTH-1:0] ptr_y_reg;
    logic [COORD_WIDTH-1:0] ptr_x_next;
    logic [COORD_WIDTH-1:0] ptr_y_next;
    logic                   result_valid_reg;
    logic [POS_W-1:0]       pos_x_reg;
    logic [POS_W-1:0]       pos_y_reg;
    logic [BTN_W-1:0]       buttons_reg;

    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_wheel;
    logic [SUM_W-1:0]        clamp_y;

    always_comb
    begin
        sum_x      = $signed(SUM_W'(ptr_x_reg)) + SUM_W'(pkt.move_x);
        sum_y      = $signed(SUM_W'(ptr_y_reg)) - SUM_W'(pkt.move_y);
        clamp_y    = clamp_coord(sum_y, cfg.bound_y);
        // wheel moves the already clamped y and clamps once more
        sum_wheel  = $signed(clamp_y) + SUM_W'(pkt.lift);
        ptr_x_next = COORD_WIDTH'(clamp_coord(sum_x, cfg.bound_x));
        ptr_y_next = COORD_WIDTH'(clamp_coord(sum_wheel, cfg.bound_y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_x_reg        <= COORD_WIDTH'(PTR_X_RST);
            ptr_y_reg        <= COORD_WIDTH'(PTR_Y_RST);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (recenter.set_x)
            begin
                ptr_x_reg <= COORD_WIDTH'(cfg.bound_x >> 1);
            end
            else if (drain)
            begin
                ptr_x_reg <= ptr_x_next;
            end
            if (recenter.set_y)
            begin
                ptr_y_reg <= COORD_WIDTH'(cfg.bound_y >> 1);
            end
            else if (drain)
            begin
                ptr_y_reg <= ptr_y_next;
            end
            if (drain)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            pos_x_reg   <= POS_W'(ptr_x_next);
            pos_y_reg   <= POS_W'(ptr_y_next);
            buttons_reg <= pkt.buttons;
        end
    end

    assign result_valid = result_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign button_bits  = buttons_reg;

endmodule

>>> rtl/mouse_packet_pointer_tracker_unit.sv
// the word that completes a packet goes to the packet register, then to the result register
// throughput: one data word per cycle unless stalled; framing and delta scaling in the
// first register stage, pointer add and clamp against the stored position in the second
// words that only extend a packet or are dropped for resync give no result
// reset: pointer at 400/300, bounds 1024/768, scale 2, 3-byte packets, framing at byte 0
module mouse_packet_pointer_tracker_unit
    import mppt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        data_byte,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [POS_W-1:0]  pos_x,
    output logic [POS_W-1:0]  pos_y,
    output logic [BTN_W-1:0]  button_bits,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t      cfg;
    recenter_t recenter;
    pkt_t      pkt;
    logic      pkt_valid;
    logic      drain;
    logic      accept;

    assign drain      = pkt_valid && (!result_valid || !result_stall);
    assign byte_stall = pkt_valid && !drain;
    assign accept     = byte_valid && !byte_stall;

    mppt_regs #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .recenter (recenter)
    );

    mppt_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .cfg       (cfg),
        .drain     (drain),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    mppt_mover #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_mover (
        .clk          (clk),
        .rst_n        (rst_n),
        .drain        (drain),
        .pkt          (pkt),
        .cfg          (cfg),
        .recenter     (recenter),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .button_bits  (button_bits)
    );

`ifndef SYNTH
    a_x_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, pos_x} < cfg.bound_x))
        else $error("pos_x outside bound");

    a_y_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, pos_y} < cfg.bound_y))
        else $error("pos_y outside bound");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (pkt_valid && result_valid && result_stall))
        else $error("input stalled with room in the packet stage");

    a_drain_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        drain |=> result_valid)
        else $error("packet taken without a result");
`endif

endmodule

>>> test/mppt_report_checker.sv
`timescale 1ns / 100ps
module mppt_report_checker
    import mppt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              byte_stall,
    input  logic [7:0]        data_byte,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_y,
    input  logic [BTN_W-1:0]  button_bits,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                mismatch_count,
    output int                pending_count
);

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [BTN_W-1:0] buttons;
    } pointer_report_t;

    pointer_report_t expected_reports[$];

    logic             four_byte;
    logic             wheel_en;
    logic             extra_en;
    int               bound_x;
    int               bound_y;
    int               scale;
    int               frame_pos;
    logic [7:0]       frame_bytes [3];
    int               ptr_x;
    int               ptr_y;
    logic [BTN_W-1:0] buttons_held;

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    function automatic int clamp_to(input int v, input int b);
        if (v < 0)
        begin
            return 0;
        end
        if (v >= b)
        begin
            return b - 1;
        end
        return v;
    endfunction

    function automatic int fit_bound(input logic [DATA_W-1:0] value, input int old);
        int v;
        v = int'(value[BOUND_W-1:0]);
        if (v == 0)
        begin
            return old;
        end
        if (v > (1 << POS_W))
        begin
            return 1 << POS_W;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        int s;
        case (idx)
            REG_FOUR_BYTE: four_byte = value[0];
            REG_WHEEL_EN:  wheel_en  = value[0];
            REG_EXTRA_EN:  extra_en  = value[0];
            REG_BOUND_X:
            begin
                bound_x = fit_bound(value, bound_x);
                ptr_x   = bound_x / 2;
            end
            REG_BOUND_Y:
            begin
                bound_y = fit_bound(value, bound_y);
                ptr_y   = bound_y / 2;
            end
            REG_SCALE:
            begin
                s = int'(value[SCALE_W-1:0]);
                if (s < int'(SCALE_MIN))
                begin
                    s = int'(SCALE_MIN);
                end
                if (s > int'(SCALE_MAX))
                begin
                    s = int'(SCALE_MAX);
                end
                scale = s;
            end
            default: ;
        endcase
    endtask

    task automatic take_byte(input logic [7:0] b);
        int              size;
        int              dx;
        int              dy;
        int              wheel;
        logic [7:0]      hdr;
        pointer_report_t r;
        size = four_byte ? 4 : 3;
        if (frame_pos == 0 && !b[3])
        begin
            return;
        end
        if (frame_pos < 3)
        begin
            frame_bytes[frame_pos] = b;
        end
        if (frame_pos + 1 < size)
        begin
            frame_pos++;
            return;
        end
        frame_pos = 0;
        hdr = frame_bytes[0];
        dx  = int'(frame_bytes[1]);
        dy  = int'(frame_bytes[2]);
        if (hdr[4])
        begin
            dx -= 256;
        end
        if (hdr[5])
        begin
            dy -= 256;
        end
        if (hdr[6])
        begin
            dx = 0;
        end
        if (hdr[7])
        begin
            dy = 0;
        end
        ptr_x = clamp_to(ptr_x + dx * scale, bound_x);
        ptr_y = clamp_to(ptr_y - dy * scale, bound_y);
        buttons_held = {2'b00, hdr[2:0]};
        if (size == 4)
        begin
            if (extra_en)
            begin
                buttons_held[3] = b[4];
                buttons_held[4] = b[5];
            end
            if (wheel_en)
            begin
                wheel = int'($signed(b[3:0]));
                ptr_y = clamp_to(ptr_y - wheel * int'(WHEEL_STEP), bound_y);
            end
        end
        r.x       = ptr_x[POS_W-1:0];
        r.y       = ptr_y[POS_W-1:0];
        r.buttons = buttons_held;
        expected_reports.push_back(r);
    endtask

    task automatic check_report();
        pointer_report_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch($sformatf("result with none pending: x %0d y %0d buttons %0d",
                                      pos_x, pos_y, button_bits));
            return;
        end
        want = expected_reports.pop_front();
        if (pos_x !== want.x)
        begin
            report_mismatch($sformatf("pos_x got %0d, expected %0d", pos_x, want.x));
        end
        if (pos_y !== want.y)
        begin
            report_mismatch($sformatf("pos_y got %0d, expected %0d", pos_y, want.y));
        end
        if (button_bits !== want.buttons)
        begin
            report_mismatch($sformatf("button_bits got %0d, expected %0d",
                                      button_bits, want.buttons));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_byte    = 1'b0;
            wheel_en     = 1'b0;
            extra_en     = 1'b0;
            bound_x      = int'(BOUND_X_RST);
            bound_y      = int'(BOUND_Y_RST);
            scale        = int'(SCALE_RST);
            frame_pos    = 0;
            ptr_x        = PTR_X_RST;
            ptr_y        = PTR_Y_RST;
            buttons_held = '0;
            expected_reports.delete();
            pending_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                write_register(paddr[ADDR_W-1:2], pwdata);
            end
            if (result_valid && !result_stall)
            begin
                check_report();
            end
            if (byte_valid && !byte_stall)
            begin
                take_byte(data_byte);
            end
            pending_count = expected_reports.size();
        end
    end

endmodule

>>> test/tb_mouse_packet_pointer_tracker_unit.sv
`timescale 1ns / 100ps
module tb_mouse_packet_pointer_tracker_unit;
    import mppt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_stall;
    logic [7:0]        data_byte;
    logic              result_valid;
    logic              result_stall;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [BTN_W-1:0]  button_bits;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   mismatch_count;
    int   pending_count;
    int   cycle_count;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic four_byte_mode = 1'b0;

    mouse_packet_pointer_tracker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .button_bits  (button_bits),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    mppt_report_checker report_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .button_bits    (button_bits),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        if (idx == REG_FOUR_BYTE)
        begin
            four_byte_mode = value[0];
        end
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        @(negedge clk);
    endtask

    // hold off until every pending report is out and the pipe has emptied
    task automatic drain();
        byte_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_bound();
        case ($urandom_range(5))
            0:       return 32'd1;
            1:       return 32'd4096;
            2:       return $urandom();
            3:       return 32'($urandom_range(2, 64));
            default: return 32'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic randomize_registers();
        apb_write(REG_FOUR_BYTE, $urandom());
        apb_write(REG_WHEEL_EN, $urandom());
        apb_write(REG_EXTRA_EN, $urandom());
        apb_write(REG_BOUND_X, pick_bound());
        apb_write(REG_BOUND_Y, pick_bound());
        apb_write(REG_SCALE, 32'($urandom_range(15)));
    endtask

    task automatic random_traffic(input int n_bytes);
        int         sent;
        int         k;
        logic [7:0] hdr;
        sent = 0;
        while (sent < n_bytes)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                hdr    = 8'($urandom_range(255));
                hdr[3] = 1'b1;
                if ($urandom_range(9) != 0)
                begin
                    hdr[7:6] = 2'b00;
                end
                send_byte(hdr);
                for (k = 0; k < (four_byte_mode ? 3 : 2); k++)
                begin
                    send_byte(8'($urandom_range(255)));
                end
                sent += four_byte_mode ? 4 : 3;
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        data_byte    = 8'h00;
        result_stall = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // resync drops, then motion extremes with default registers
        send_byte(8'h00);
        send_byte(8'hF7);
        send_byte(8'h0F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h38);
        send_byte(8'h00);
        send_byte(8'h80);
        drain();

        // extension bits have no effect with 3-byte packets
        apb_write(REG_WHEEL_EN, 32'd1);
        apb_write(REG_EXTRA_EN, 32'd1);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);

        // packet size switched mid-packet, both directions
        send_byte(8'h08);
        send_byte(8'h02);
        drain();
        apb_write(REG_FOUR_BYTE, 32'd1);
        send_byte(8'h03);
        send_byte(8'h3F);
        send_byte(8'h09);
        send_byte(8'h01);
        send_byte(8'h01);
        drain();
        apb_write(REG_FOUR_BYTE, 32'd0);
        send_byte(8'h77);
        drain();

        // bound and scale extremes, out-of-range writes
        apb_write(REG_BOUND_X, 32'd0);
        apb_write(REG_BOUND_Y, 32'h0000_1FFF);
        apb_write(REG_SCALE, 32'd0);
        send_byte(8'h28);
        send_byte(8'h05);
        send_byte(8'hFB);
        drain();
        apb_write(REG_BOUND_X, 32'd1);
        apb_write(REG_BOUND_Y, 32'd1);
        apb_write(REG_SCALE, 32'd15);
        send_byte(8'h18);
        send_byte(8'h80);
        send_byte(8'h7F);
        drain();
        apb_write(REG_BOUND_X, 32'h0000_2000);
        apb_write(REG_BOUND_X, 32'd4096);
        apb_write(REG_BOUND_Y, 32'hFFFF_FFFF);
        apb_write(REG_SCALE, 32'd8);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 76;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 11;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                drain();
                randomize_registers();
                random_traffic(125);
            end
        end

        drain();
        repeat (6) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mppt_pkg.sv
rtl/mppt_regs.sv
rtl/mppt_framer.sv
rtl/mppt_mover.sv
rtl/mouse_packet_pointer_tracker_unit.sv
test/mppt_report_checker.sv
test/tb_mouse_packet_pointer_tracker_unit.sv
